// ===== rtl/core/frst_pkg.sv =====
package frst_pkg;

	localparam int ENTRIES_DEF = 16;

	localparam int ID_W   = 16;
	localparam int TIME_W = 32;
	localparam int TMO_W  = 16;
	localparam int SLOT_W = 4;
	localparam int CNT_W  = 5;

	localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd30;
	localparam logic [CNT_W-1:0] CNT_MAX     = '1;

	typedef enum logic [0:0] {
		OP_LOOKUP = 1'b0,
		OP_SWEEP  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_HIT   = 2'd0,
		ST_NEW   = 2'd1,
		ST_FULL  = 2'd2,
		ST_SWEPT = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

endpackage

// ===== rtl/core/frst_if.sv =====
interface frst_req_if
	import frst_pkg::*;
();
	logic              valid;
	logic              ready;
	op_t               opcode;
	logic [ID_W-1:0]   pkt_id;
	logic [TIME_W-1:0] now_seconds;

	modport source (output valid, opcode, pkt_id, now_seconds, input ready);
	modport sink   (input valid, opcode, pkt_id, now_seconds, output ready);
endinterface

interface frst_rsp_if
	import frst_pkg::*;
();
	logic              valid;
	logic              ready;
	status_t           status;
	logic [SLOT_W-1:0] slot_index;
	logic [CNT_W-1:0]  expired_count;

	modport source (output valid, status, slot_index, expired_count, input ready);
	modport sink   (input valid, status, slot_index, expired_count, output ready);
endinterface

interface frst_cfg_if
	import frst_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [TMO_W-1:0] timeout_seconds;

	modport source (output valid, timeout_seconds, input ready);
	modport sink   (input valid, timeout_seconds, output ready);
endinterface

// ===== rtl/core/fragment_reassembly_slot_table.sv =====
// Slot table for packet reassembly with idle timeout. Every request word
// (lookup or sweep) scans all ENTRIES slots once through a single-port
// memory holding packet id and last-seen time, one slot per cycle. The
// result word is registered in the finish step, and the next request is
// accepted only once the block is back in idle, so a request is not taken
// while an earlier one is still being scanned; the scan over the memory
// read port bounds the request rate, and a result left waiting on rsp
// stalls the next item in its finish step. Active flags live in
// flip-flops and are cleared by reset, so no clearing pass is needed.
// A new request is taken while a finished result still waits on rsp.
// The timeout register may be written over cfg whenever the block is idle.
module fragment_reassembly_slot_table
	import frst_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	frst_req_if.sink    req,
	frst_rsp_if.source  rsp,
	frst_cfg_if.sink    cfg
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = IW + 1;
	localparam int MW = ID_W + TIME_W;

	state_t state_q, state_d;

	logic [TMO_W-1:0]  timeout_q;
	op_t               op_q;
	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] now_q;

	logic [CW-1:0]     cnt_q;
	logic [ENTRIES-1:0] active_q;
	logic [MW-1:0]     mem [ENTRIES];

	logic              vld_s1;
	logic [IW-1:0]     idx_s1;
	logic              act_s1;
	logic [MW-1:0]     rd_s1;

	logic              hit_q, free_q;
	logic [IW-1:0]     hit_idx_q, free_idx_q;
	logic [CNT_W-1:0]  freed_q;

	logic              out_valid_q;
	status_t           status_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  count_q;
	logic [IW-1:0]     res_idx_q;

	logic              acc;
	logic              issue;
	logic              last_s1;
	logic              fin_fire;
	logic              id_eq;
	logic              aged;
	logic [TIME_W-1:0] age;

	assign acc     = req.valid && req.ready;
	assign last_s1 = vld_s1 && (idx_s1 == IW'(ENTRIES - 1));
	assign id_eq   = rd_s1[MW-1 -: ID_W] == id_q;
	assign age     = now_q - rd_s1[TIME_W-1:0];
	assign aged    = age > {{(TIME_W-TMO_W){1'b0}}, timeout_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (acc) state_d = S_SCAN;
			S_SCAN:   if (last_s1) state_d = S_FINISH;
			S_FINISH: if (!out_valid_q || rsp.ready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		issue     = 1'b0;
		fin_fire  = 1'b0;
		case (state_q)
			S_IDLE:   req.ready = 1'b1;
			S_SCAN:   issue = cnt_q < CW'(ENTRIES);
			S_FINISH: fin_fire = !out_valid_q || rsp.ready;
			default:  ;
		endcase
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			timeout_q <= TIMEOUT_RST;
		end else begin
			state_q <= state_d;
			if (cfg.valid) timeout_q <= cfg.timeout_seconds;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_q  <= req.opcode;
			id_q  <= req.pkt_id;
			now_q <= req.now_seconds;
		end
	end

	// scan address and read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (acc) cnt_q <= '0;
			else if (issue) cnt_q <= cnt_q + 1'b1;
			vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_s1  <= mem[cnt_q[IW-1:0]];
			idx_s1 <= cnt_q[IW-1:0];
			act_s1 <= active_q[cnt_q[IW-1:0]];
		end
		if (fin_fire && op_q == OP_LOOKUP && (hit_q || free_q))
			mem[hit_q ? hit_idx_q : free_idx_q] <= {id_q, now_q};
	end

	// scan results: first match, first free slot, expired tally
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
			freed_q <= '0;
		end else if (acc) begin
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
			freed_q <= '0;
		end else if (vld_s1) begin
			if (op_q == OP_LOOKUP) begin
				if (act_s1 && id_eq && !hit_q) hit_q <= 1'b1;
				if (!act_s1 && !free_q) free_q <= 1'b1;
			end else if (act_s1 && aged && freed_q != CNT_MAX) begin
				freed_q <= freed_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && op_q == OP_LOOKUP) begin
			if (act_s1 && id_eq && !hit_q) hit_idx_q <= idx_s1;
			if (!act_s1 && !free_q) free_idx_q <= idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else begin
			// drop expired slots as the scan passes them
			if (vld_s1 && op_q == OP_SWEEP && act_s1 && aged)
				active_q[idx_s1] <= 1'b0;
			if (fin_fire && op_q == OP_LOOKUP && !hit_q && free_q)
				active_q[free_idx_q] <= 1'b1;
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire) begin
			count_q   <= '0;
			slot_q    <= '0;
			res_idx_q <= '0;
			if (op_q == OP_SWEEP) begin
				status_q <= ST_SWEPT;
				count_q  <= freed_q;
			end else if (hit_q) begin
				status_q  <= ST_HIT;
				slot_q    <= SLOT_W'(hit_idx_q);
				res_idx_q <= hit_idx_q;
			end else if (free_q) begin
				status_q  <= ST_NEW;
				slot_q    <= SLOT_W'(free_idx_q);
				res_idx_q <= free_idx_q;
			end else begin
				status_q <= ST_FULL;
			end
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = status_q;
	assign rsp.slot_index    = slot_q;
	assign rsp.expired_count = count_q;

	a_sweep_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_SWEPT |-> rsp.slot_index == '0)
		else $error("sweep result carries a slot index");

	a_lookup_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ST_SWEPT |-> rsp.expired_count == '0)
		else $error("lookup result carries an expired count");

	a_new_is_active: assert property (@(posedge clk) disable iff (!arst_n)
		fin_fire |=> (status_q != ST_NEW && status_q != ST_HIT) || active_q[res_idx_q])
		else $error("hit or created slot is not active");

	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> state_q == S_SCAN && cnt_q == '0)
		else $error("accepted word did not start a scan");

endmodule
